// ===== rtl/core/int32_to_fp12_round_even_core_defines.svh =====
// Assertion macros shared by the int32 to fp12 converter RTL.
// Depends on nothing; expects signals named clock and reset in the using module.
`ifndef INT32_TO_FP12_ROUND_EVEN_CORE_DEFINES_SVH
`define INT32_TO_FP12_ROUND_EVEN_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define I2FP_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define I2FP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/i2fp12_pkg.sv =====
// Types and constants for the int32 to fp12 converter.
// No dependencies.
package i2fp12_pkg;

   localparam logic [5:0] EXP_TOP  = 6'd62;   // exponent of 2^31
   localparam logic [5:0] EXP_INF  = 6'd63;
   localparam int unsigned SIGN_COPIES = 5;

   // after sign/magnitude split
   typedef struct packed {
      logic        sign;
      logic        zero;
      logic [31:0] mag;
   } s1_type;

   // after coarse normalization (shifts of 16, 8, 4)
   typedef struct packed {
      logic        sign;
      logic        zero;
      logic [31:0] mag;
      logic [2:0]  lz_hi;
   } s2_type;

   // after fine normalization, fields ready for rounding
   typedef struct packed {
      logic       sign;
      logic       zero;
      logic [5:0] expo;
      logic [5:0] frac;    // hidden one plus five fraction bits
      logic       guard;
      logic       sticky;
   } s3_type;

endpackage

// ===== rtl/core/int32_to_fp12_round_even_core.sv =====
// Throughput one item per cycle; accepted items pass stages 1 to 4 to rsp_strobe.
// busy is held low: every stage advances every cycle and results cannot be stalled.
// Reset (synchronous, active high) clears the stage valid bits only; no item in flight
// survives it and rsp_strobe is low in the cycle after reset.
// Depends on i2fp12_pkg and int32_to_fp12_round_even_core_defines.svh.
`include "int32_to_fp12_round_even_core_defines.svh"

module int32_to_fp12_round_even_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_int_value,
   output logic        rsp_strobe,
   output logic [15:0] rsp_fp12_word
);
   import i2fp12_pkg::*;

   // Pipeline:
   //   stage 1  two's-complement magnitude, zero and sign flags
   //   stage 2  normalize by 16, 8, 4 (upper three leading-zero bits)
   //   stage 3  normalize by 2, 1; exponent, guard and sticky
   //   stage 4  round to nearest even, carry into exponent, pack (output register)

   logic        accept;

   logic        s1_valid_ff, s2_valid_ff, s3_valid_ff, out_valid_ff;
   s1_type      s1_ff, s1_in;
   s2_type      s2_ff, s2_in;
   s3_type      s3_ff, s3_in;
   logic [15:0] out_word_ff, out_word_in;

   assign busy   = 1'b0;
   assign accept = start & ~busy;

   // ---- stage 1: sign and magnitude -------------------------------------------
   // the most negative value negates to itself, read unsigned as 2^31
   always_comb begin
      s1_in.sign = req_int_value[31];
      s1_in.zero = (req_int_value == 32'd0);
      s1_in.mag  = req_int_value[31] ? (32'd0 - req_int_value) : req_int_value;
   end

   // ---- stage 2: coarse leading-zero normalization ----------------------------
   always_comb begin
      logic [31:0] n;
      n           = s1_ff.mag;
      s2_in.lz_hi = 3'd0;
      if (n[31:16] == 16'd0) begin
         s2_in.lz_hi[2] = 1'b1;
         n              = n << 16;
      end
      if (n[31:24] == 8'd0) begin
         s2_in.lz_hi[1] = 1'b1;
         n              = n << 8;
      end
      if (n[31:28] == 4'd0) begin
         s2_in.lz_hi[0] = 1'b1;
         n              = n << 4;
      end
      s2_in.sign = s1_ff.sign;
      s2_in.zero = s1_ff.zero;
      s2_in.mag  = n;
   end

   // ---- stage 3: fine normalization, exponent, round bits ---------------------
   always_comb begin
      logic [31:0] n;
      logic [1:0]  lz_lo;
      n     = s2_ff.mag;
      lz_lo = 2'd0;
      if (n[31:30] == 2'd0) begin
         lz_lo[1] = 1'b1;
         n        = n << 2;
      end
      if (n[31] == 1'b0) begin
         lz_lo[0] = 1'b1;
         n        = n << 1;
      end
      s3_in.sign   = s2_ff.sign;
      s3_in.zero   = s2_ff.zero;
      s3_in.expo   = EXP_TOP - {1'b0, s2_ff.lz_hi, lz_lo};
      s3_in.frac   = n[31:26];
      s3_in.guard  = n[25];
      s3_in.sticky = |n[24:0];
   end

   // ---- stage 4: round to nearest even and pack -------------------------------
   always_comb begin
      logic       inc;
      logic [6:0] sum;
      logic [5:0] expo;
      logic [4:0] frac;
      inc  = s3_ff.guard & (s3_ff.sticky | s3_ff.frac[0]);
      sum  = {1'b0, s3_ff.frac} + {6'd0, inc};
      expo = s3_ff.expo;
      frac = sum[4:0];
      if (sum[6]) begin
         // carry out of the fraction: mantissa becomes 1.00000
         frac = 5'd0;
         expo = (s3_ff.expo == EXP_TOP) ? EXP_INF : s3_ff.expo + 6'd1;
      end
      if (s3_ff.zero) begin
         out_word_in = 16'd0;
      end else begin
         out_word_in = {{SIGN_COPIES{s3_ff.sign}}, expo, frac};
      end
   end

   // ---- registers -------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= accept;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         out_valid_ff <= s3_valid_ff;
      end
   end

   // payload: no reset, loaded every cycle
   always_ff @(posedge clock) begin
      s1_ff       <= s1_in;
      s2_ff       <= s2_in;
      s3_ff       <= s3_in;
      out_word_ff <= out_word_in;
   end

   assign rsp_strobe    = out_valid_ff;
   assign rsp_fp12_word = out_word_ff;

   // ---- assertions ------------------------------------------------------------
   `I2FP_ASSERT_NEXT(a_valid_chain, s1_valid_ff, s2_valid_ff, "valid lost between stages")
   `I2FP_ASSERT_NOW(a_normalized, s3_valid_ff && !s3_ff.zero, s3_ff.frac[5], "leading one missing")
   `I2FP_ASSERT_NEXT(a_zero_word, s3_valid_ff && s3_ff.zero, rsp_fp12_word == 16'd0, "zero not zero")
   `I2FP_ASSERT_NOW(a_sign_copies, rsp_strobe, ($countones(rsp_fp12_word[15:11]) == 0) || ($countones(rsp_fp12_word[15:11]) == 5), "sign copies differ")
   `I2FP_ASSERT_NOW(a_inf_frac, rsp_strobe && (rsp_fp12_word[10:5] == EXP_INF), rsp_fp12_word[4:0] == 5'd0, "infinity with fraction")

endmodule
